/* design/mpe_pkg.sv */
`default_nettype none
package mpe_pkg;

   localparam int MAX_DIGITS_DEF = 16;
   localparam int VAL_W = 64;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL
   } mpe_op_type;

   typedef struct packed {
      logic [3:0] digit;
      logic [1:0] op;
      logic       last;
   } mpe_req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] max_value;
      logic                    truncated;
   } mpe_rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD_A,
      S_RD_B,
      S_CAP_B,
      S_MUL,
      S_SUM,
      S_CMP,
      S_WR,
      S_FIN_RD,
      S_FIN_CAP
   } mpe_state_type;

   typedef struct packed {
      logic       mul_en;
      logic       sum_en;
      logic [1:0] corner;
   } mpe_corner_ctl_type;

endpackage
`default_nettype wire

/* design/mpe_ram.sv */
`default_nettype none
module mpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

/* design/mpe_corner.sv */
`default_nettype none
module mpe_corner (
   input  wire logic                       clock,
   input  wire mpe_pkg::mpe_corner_ctl_type ctl,
   input  wire logic [1:0]                 op,
   input  wire logic [127:0]               half_a,
   input  wire logic [127:0]               half_b,
   output logic      [63:0]                value
);
   import mpe_pkg::*;

   logic [63:0] a;
   logic [63:0] b;
   logic [63:0] p0_ff;
   logic [31:0] p1_ff;
   logic [31:0] p2_ff;
   logic [63:0] sum_ff;
   logic [63:0] dif_ff;
   logic [63:0] prod;
   logic [63:0] value_in;
   logic [63:0] value_ff;

   // halves hold {max, min}; corner bit 1 picks left max, bit 0 right max
   assign a = ctl.corner[1] ? half_a[127:64] : half_a[63:0];
   assign b = ctl.corner[0] ? half_b[127:64] : half_b[63:0];

   // low 64 bits of the product from three 32x32 partial products
   assign prod = p0_ff + {p1_ff + p2_ff, 32'd0};

   always_comb begin
      case (mpe_op_type'(op))
         OP_ADD:  value_in = sum_ff;
         OP_SUB:  value_in = dif_ff;
         default: value_in = prod;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         p0_ff  <= a[31:0] * b[31:0];
         p1_ff  <= 32'(a[63:32] * b[31:0]);
         p2_ff  <= 32'(a[31:0] * b[63:32]);
         sum_ff <= a + b;
         dif_ff <= a - b;
      end
      if (ctl.sum_en) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule
`default_nettype wire

/* design/max_parenthesized_expression.sv */
`default_nettype none
// channel   ports                 handshake
// request   start, busy, req_data accepted when start high and busy low
// result    rsp_strobe, rsp_data  one cycle, receiver cannot hold off
//
// loading accepts one digit per cycle while busy is low; a non-last item
// leaves busy low. the last item starts the interval pass, skipped for a
// single digit: per split point table reads in S_RD_A, S_RD_B and S_CAP_B,
// then S_MUL, S_SUM and S_CMP per corner through the shared multiplier, one
// write per interval, then S_FIN_RD and S_FIN_CAP read out the full range.
// synchronous reset clears the sequencer, digit count and overflow flag.
module max_parenthesized_expression #(
   parameter int MAX_DIGITS = mpe_pkg::MAX_DIGITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire mpe_pkg::mpe_req_type req_data,
   output logic                      rsp_strobe,
   output mpe_pkg::mpe_rsp_type      rsp_data
);
   import mpe_pkg::*;

   localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CW = $clog2(MAX_DIGITS + 1);
   localparam int TD = 1 << (2 * IW);

   mpe_state_type      state_ff, state_in;
   logic [CW-1:0]      cnt_ff;
   logic               ovf_ff;
   logic [IW-1:0]      span_ff, i_ff, k_ff;
   logic [IW-1:0]      j;
   logic [1:0]         t_ff;
   logic [1:0]         op_ff;
   logic [127:0]       a_ff, b_ff;
   logic [63:0]        lo_ff, hi_ff;
   logic               strobe_ff;
   mpe_rsp_type        rsp_ff;

   logic               accept;
   logic               tbl_we;
   logic [2*IW-1:0]    tbl_waddr, tbl_raddr;
   logic [127:0]       tbl_wdata, tbl_rdata;
   logic               ops_we;
   logic [1:0]         ops_rdata;
   logic [63:0]        cval;
   mpe_corner_ctl_type cctl;

   logic               k_more, i_more, span_more;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);
   assign j      = IW'(i_ff + span_ff);

   assign k_more    = ({1'b0, k_ff} + (IW+1)'(1)) < {1'b0, j};
   assign i_more    = ((CW+1)'(j) + (CW+1)'(1)) < (CW+1)'(cnt_ff);
   assign span_more = ((CW+1)'(span_ff) + (CW+1)'(1)) < (CW+1)'(cnt_ff);

   mpe_ram #(.WIDTH(128), .DEPTH(TD)) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata)
   );

   mpe_ram #(.WIDTH(2), .DEPTH(MAX_DIGITS)) u_ops (
      .clock   (clock),
      .wr_en   (ops_we),
      .wr_addr ($clog2(MAX_DIGITS)'(cnt_ff)),
      .wr_data (req_data.op),
      .rd_addr ($clog2(MAX_DIGITS)'(k_ff)),
      .rd_data (ops_rdata)
   );

   mpe_corner u_corner (
      .clock  (clock),
      .ctl    (cctl),
      .op     (op_ff),
      .half_a (a_ff),
      .half_b (b_ff),
      .value  (cval)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_data.last) begin
               state_in = S_FIN_RD;
               if ((cnt_ff < CW'(MAX_DIGITS) ? cnt_ff + CW'(1) : cnt_ff) > CW'(1)) begin
                  state_in = S_RD_A;
               end
            end
         end
         S_RD_A:    state_in = S_RD_B;
         S_RD_B:    state_in = S_CAP_B;
         S_CAP_B:   state_in = S_MUL;
         S_MUL:     state_in = S_SUM;
         S_SUM:     state_in = S_CMP;
         S_CMP: begin
            if (t_ff != 2'd3)  state_in = S_MUL;
            else if (k_more)   state_in = S_RD_A;
            else               state_in = S_WR;
         end
         S_WR:      state_in = (i_more || span_more) ? S_RD_A : S_FIN_RD;
         S_FIN_RD:  state_in = S_FIN_CAP;
         S_FIN_CAP: state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      tbl_we      = 1'b0;
      tbl_waddr   = {IW'(cnt_ff), IW'(cnt_ff)};
      tbl_wdata   = {60'd0, req_data.digit, 60'd0, req_data.digit};
      tbl_raddr   = {i_ff, k_ff};
      ops_we      = 1'b0;
      cctl.mul_en = 1'b0;
      cctl.sum_en = 1'b0;
      cctl.corner = t_ff;
      unique case (state_ff)
         S_IDLE: begin
            tbl_we = accept && (cnt_ff < CW'(MAX_DIGITS));
            ops_we = tbl_we;
         end
         S_RD_B:   tbl_raddr = {IW'(k_ff + IW'(1)), j};
         S_MUL:    cctl.mul_en = 1'b1;
         S_SUM:    cctl.sum_en = 1'b1;
         S_WR: begin
            tbl_we    = 1'b1;
            tbl_waddr = {i_ff, j};
            tbl_wdata = {hi_ff, lo_ff};
         end
         S_FIN_RD: tbl_raddr = {IW'(0), IW'(cnt_ff - CW'(1))};
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         ovf_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= (state_ff == S_FIN_CAP);
         if (state_ff == S_IDLE && accept) begin
            if (cnt_ff < CW'(MAX_DIGITS)) cnt_ff <= cnt_ff + CW'(1);
            else                          ovf_ff <= 1'b1;
         end
         if (state_ff == S_FIN_CAP) begin
            cnt_ff <= '0;
            ovf_ff <= 1'b0;
         end
      end
   end

   // loop counters and interval datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            span_ff <= IW'(1);
            i_ff    <= '0;
            k_ff    <= '0;
            t_ff    <= '0;
            lo_ff   <= {1'b0, {63{1'b1}}};
            hi_ff   <= {1'b1, 63'd0};
         end
         S_RD_B:  begin
            a_ff  <= tbl_rdata;
            op_ff <= ops_rdata;
         end
         S_CAP_B: b_ff <= tbl_rdata;
         S_CMP: begin
            if ($signed(cval) < $signed(lo_ff)) lo_ff <= cval;
            if ($signed(cval) > $signed(hi_ff)) hi_ff <= cval;
            t_ff <= t_ff + 2'd1;
            if (t_ff == 2'd3 && k_more) k_ff <= k_ff + IW'(1);
         end
         S_WR: begin
            lo_ff <= {1'b0, {63{1'b1}}};
            hi_ff <= {1'b1, 63'd0};
            if (i_more) begin
               i_ff <= i_ff + IW'(1);
               k_ff <= i_ff + IW'(1);
            end else begin
               span_ff <= span_ff + IW'(1);
               i_ff    <= '0;
               k_ff    <= '0;
            end
         end
         S_FIN_CAP: begin
            rsp_ff.max_value <= tbl_rdata[127:64];
            rsp_ff.truncated <= ovf_ff;
         end
         default: ;
      endcase
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef SYNTHESIS
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without a preceding solve");
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result repeated");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_DIGITS))
      else $error("digit count beyond capacity");
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WR) |-> ((CW+1)'(j) < (CW+1)'(cnt_ff)))
      else $error("interval write beyond stored digits");
`endif

endmodule
`default_nettype wire

/* sim/tb.sv */
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mpe_pkg::*;

   localparam int CAPACITY = MAX_DIGITS_DEF;
   localparam int RANDOM_ITEMS = 650;

   typedef struct packed {
      logic [3:0]  digit;
      logic [1:0]  op;
      logic        last;
      logic        typed;
      logic [63:0] value;
      logic        trunc;
   } row_type;

   localparam row_type DIRECTED [26] = '{
      '{4'd0,  OP_ADD, 1'b1, 1'b1, 64'd0,  1'b0},
      '{4'd15, OP_MUL, 1'b1, 1'b1, 64'd15, 1'b0},
      '{4'd9,  OP_SUB, 1'b0, 1'b0, 64'd0,  1'b0},
      '{4'd9,  OP_ADD, 1'b1, 1'b1, 64'd0,  1'b0},
      '{4'd3,  2'd3,   1'b0, 1'b0, 64'd0,  1'b0},
      '{4'd4,  OP_ADD, 1'b1, 1'b1, 64'd12, 1'b0},
      '{4'd2,  OP_SUB, 1'b0, 1'b0, 64'd0,  1'b0},
      '{4'd3,  OP_MUL, 1'b0, 1'b0, 64'd0,  1'b0},
      '{4'd4,  OP_ADD, 1'b1, 1'b0, 64'd0,  1'b0},
      // capacity full: seventeenth digit is dropped, still the last one
      '{4'd15, OP_MUL, 1'b0, 1'b0, 64'd0,  1'b0},
      '{4'd15, OP_MUL, 1'b0, 1'b0, 64'd0,  1'b0},
      '{4'd15, OP_SUB, 1'b0, 1'b0, 64'd0,  1'b0},
      '{4'd15, OP_MUL, 1'b0, 1'b0, 64'd0,  1'b0},
      '{4'd15, OP_MUL, 1'b0, 1'b0, 64'd0,  1'b0},
      '{4'd15, 2'd3,   1'b0, 1'b0, 64'd0,  1'b0},
      '{4'd15, OP_MUL, 1'b0, 1'b0, 64'd0,  1'b0},
      '{4'd15, OP_MUL, 1'b0, 1'b0, 64'd0,  1'b0},
      '{4'd15, OP_ADD, 1'b0, 1'b0, 64'd0,  1'b0},
      '{4'd15, OP_MUL, 1'b0, 1'b0, 64'd0,  1'b0},
      '{4'd15, OP_MUL, 1'b0, 1'b0, 64'd0,  1'b0},
      '{4'd15, OP_MUL, 1'b0, 1'b0, 64'd0,  1'b0},
      '{4'd15, OP_SUB, 1'b0, 1'b0, 64'd0,  1'b0},
      '{4'd15, OP_MUL, 1'b0, 1'b0, 64'd0,  1'b0},
      '{4'd15, OP_MUL, 1'b0, 1'b0, 64'd0,  1'b0},
      '{4'd15, OP_MUL, 1'b0, 1'b0, 64'd0,  1'b0},
      '{4'd7,  OP_ADD, 1'b1, 1'b0, 64'd0,  1'b0}
   };

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   mpe_req_type req_data;
   logic        rsp_strobe;
   mpe_rsp_type rsp_data;

   max_parenthesized_expression dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   // expression held by the predictor
   logic [3:0]  held_digit [CAPACITY];
   logic [1:0]  held_op [CAPACITY];
   int          held_count;
   logic        held_dropped;
   mpe_rsp_type pending_max [$];
   int          mismatches;
   int          results_seen;
   int          expressions;
   int          dropped_seen;
   int          gap_pct;

   initial clock = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] combine(logic [63:0] a, logic [63:0] b, logic [1:0] code);
      if (code[1]) return a * b;
      if (code[0]) return a - b;
      return a + b;
   endfunction

   function automatic logic [63:0] best_value(int n);
      logic [63:0] lo_t [CAPACITY][CAPACITY];
      logic [63:0] hi_t [CAPACITY][CAPACITY];
      logic [63:0] lo, hi, v;
      for (int i = 0; i < n; i++) begin
         lo_t[i][i] = {60'd0, held_digit[i]};
         hi_t[i][i] = {60'd0, held_digit[i]};
      end
      for (int span = 1; span < n; span++) begin
         for (int i = 0; i + span < n; i++) begin
            lo = 64'h7fff_ffff_ffff_ffff;
            hi = 64'h8000_0000_0000_0000;
            for (int k = i; k < i + span; k++) begin
               for (int c = 0; c < 4; c++) begin
                  v = combine(c[1] ? hi_t[i][k] : lo_t[i][k],
                              c[0] ? hi_t[k+1][i+span] : lo_t[k+1][i+span], held_op[k]);
                  if ($signed(v) < $signed(lo)) lo = v;
                  if ($signed(v) > $signed(hi)) hi = v;
               end
            end
            lo_t[i][i+span] = lo;
            hi_t[i][i+span] = hi;
         end
      end
      return hi_t[0][n-1];
   endfunction

   // drives one item, waits for it to be taken, then updates the predictor
   task automatic send_digit(logic [3:0] d, logic [1:0] o, logic l,
                             logic typed, logic [63:0] tv, logic tt);
      mpe_rsp_type e;
      start <= 1'b1;
      req_data <= '{digit: d, op: o, last: l};
      do @(posedge clock); while (busy);
      if (held_count < CAPACITY) begin
         held_digit[held_count] = d;
         held_op[held_count] = o;
         held_count++;
      end else begin
         held_dropped = 1'b1;
      end
      if (l) begin
         e.max_value = best_value(held_count);
         e.truncated = held_dropped;
         if (typed) begin
            e.max_value = tv;
            e.truncated = tt;
         end
         if (held_dropped) dropped_seen++;
         pending_max.push_back(e);
         expressions++;
         held_count = 0;
         held_dropped = 1'b0;
      end
   endtask

   task automatic maybe_idle();
      if ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (pending_max.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: max %0d trunc %0b",
                        rsp_data.max_value, rsp_data.truncated);
         end else begin
            if (rsp_data.max_value !== pending_max[0].max_value ||
                rsp_data.truncated !== pending_max[0].truncated) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected max %0d trunc %0b, got max %0d trunc %0b",
                           pending_max[0].max_value, pending_max[0].truncated,
                           rsp_data.max_value, rsp_data.truncated);
            end
            void'(pending_max.pop_front());
         end
      end
   end

   initial begin
      #50ms;
      $display("tb NOT OK");
      $finish;
   end

   initial begin
      int len;
      int sent;
      bit drained;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      held_count = 0;
      held_dropped = 1'b0;
      mismatches = 0;
      results_seen = 0;
      expressions = 0;
      dropped_seen = 0;
      gap_pct = 0;
      drained = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[r])
         send_digit(DIRECTED[r].digit, DIRECTED[r].op, DIRECTED[r].last,
                    DIRECTED[r].typed, DIRECTED[r].value, DIRECTED[r].trunc);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent < RANDOM_ITEMS / 3) gap_pct = 11;
         else if (sent < 2 * RANDOM_ITEMS / 3) gap_pct = 80;
         else gap_pct = 0;
         // hold off until the block has drained at the first phase change
         if (sent >= RANDOM_ITEMS / 3 && !drained) begin
            drained = 1'b1;
            start <= 1'b0;
            while (pending_max.size() != 0) @(posedge clock);
         end
         // mostly short expressions, a few near or past capacity
         if ($urandom_range(99) < 4) len = $urandom_range(CAPACITY - 2, CAPACITY + 4);
         else len = $urandom_range(1, 6);
         for (int i = 0; i < len; i++) begin
            maybe_idle();
            send_digit(4'($urandom_range(15)), 2'($urandom_range(3)), i == len - 1,
                       1'b0, '0, 1'b0);
         end
         sent += len;
      end
      start <= 1'b0;

      while (pending_max.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("covered %0d expressions (%0d over capacity), %0d results checked",
               expressions, dropped_seen, results_seen);
      if (mismatches == 0 && pending_max.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb NOT OK");
      end
      $finish;
   end
endmodule
`default_nettype wire
